// ----- design/viewport_to_equirect_map_macros.svh -----
// Assertion macros used by the checker file of the viewport map block.
`ifndef VIEWPORT_TO_EQUIRECT_MAP_MACROS_SVH
`define VIEWPORT_TO_EQUIRECT_MAP_MACROS_SVH

// A property checked on every rising clock edge outside reset.
`define VEM_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("%m: assertion failed");

// An implication checked on every rising clock edge outside reset.
`define VEM_ASSERT_IMPL(label, ante, cons) \
   `VEM_ASSERT(label, ((ante) |-> cons))

`endif

// ----- design/vem_pkg.sv -----
// Types, constants and tables of the viewport to equirectangular map block.
package vem_pkg;

   // Field formats.
   localparam int FRAC_BITS = 8;
   localparam int PIX_W = 12;
   localparam int FOCAL_W = 20;
   localparam int QUAT_W = 16;
   localparam int PLANE_W = 13;
   localparam int EQH_W = 12;
   localparam int EQX_W = 13 + FRAC_BITS;
   localparam int EQY_W = 12 + FRAC_BITS;

   // Register port.
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 20;
   localparam logic [CSR_IDX_W-1:0] CSR_FOCAL = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_QUAT_W = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_QUAT_X = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_QUAT_Y = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_QUAT_Z = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_PLANE_W = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_PLANE_H = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_EQUI_H = 3'd7;

   // Register reset values.
   localparam logic [FOCAL_W-1:0] FOCAL_RST = 20'd143360;
   localparam logic signed [QUAT_W-1:0] QUAT_W_RST = 16'sd16384;
   localparam logic signed [QUAT_W-1:0] QUAT_V_RST = 16'sd0;
   localparam logic [PLANE_W-1:0] PLANE_W_RST = 13'd960;
   localparam logic [PLANE_W-1:0] PLANE_H_RST = 13'd540;
   localparam logic [EQH_W-1:0] EQUI_H_RST = 12'd960;

   // Internal datapath widths.
   localparam int QPROD_W = 32;
   localparam int MAT_W = 34;
   localparam int VEC_W = 22;
   localparam int PROD_W = MAT_W + VEC_W;
   localparam int RAY_W = PROD_W + 4;
   localparam int MAG_W = RAY_W;
   localparam int LEN_W = 7;
   localparam int NORM_W = 30;
   localparam int NVEC_W = NORM_W + 1;
   localparam int SQ_W = 2 * NORM_W;
   localparam int RAD_W = SQ_W + 1;
   localparam int ROOT_W = (RAD_W + 1) / 2;
   localparam int CORD_NUM_W = 32;
   localparam int CORD_XY_W = 36;
   localparam int ANG_W = 33;
   localparam int CORDIC_STEPS = 30;
   localparam int LON_W = 34;
   localparam int SCL_W = LON_W + EQH_W + 1;
   localparam int OUT_W = SCL_W + 1;

   // Angle constants, 180 degrees is 2^31.
   localparam logic signed [ANG_W-1:0] ANG_QUARTER = 33'sd1073741824;
   localparam logic signed [LON_W-1:0] ANG_HALF = 34'sd2147483648;
   localparam logic signed [LON_W-1:0] ANG_FULL = 34'sd4294967296;

   // Pipeline depth from the accepting edge to the result strobe.
   localparam int FRONT_STAGES = 9;
   localparam int ISQRT_STAGES = ROOT_W;
   localparam int CORDIC_STAGES = CORDIC_STEPS + 1;
   localparam int BACK_STAGES = 4;
   localparam int RSP_LATENCY = FRONT_STAGES + ISQRT_STAGES + CORDIC_STAGES + BACK_STAGES;

   // Largest column any register setting can give.
   localparam logic [EQX_W-1:0] EQX_BOUND = EQX_W'((2 * 4095) << FRAC_BITS);

   typedef struct packed {
      logic [PIX_W-1:0] pixel_col;
      logic [PIX_W-1:0] pixel_row;
   } req_type;

   typedef struct packed {
      logic [EQX_W-1:0] equi_x;
      logic [EQY_W-1:0] equi_y;
   } rsp_type;

   // Arctangent of 2^-i in units where 180 degrees is 2^31.
   function automatic logic signed [ANG_W-1:0] cordic_arc(input int i);
      logic [31:0] a;
      unique case (i)
         0: a = 32'h20000000;   1: a = 32'h12E4051E;   2: a = 32'h09FB385B;
         3: a = 32'h051111D4;   4: a = 32'h028B0D43;   5: a = 32'h0145D7E1;
         6: a = 32'h00A2F61E;   7: a = 32'h00517C55;   8: a = 32'h0028BE53;
         9: a = 32'h00145F2F;  10: a = 32'h000A2F98;  11: a = 32'h000517CC;
        12: a = 32'h00028BE6;  13: a = 32'h000145F3;  14: a = 32'h0000A2FA;
        15: a = 32'h0000517D;  16: a = 32'h000028BE;  17: a = 32'h0000145F;
        18: a = 32'h00000A30;  19: a = 32'h00000518;  20: a = 32'h0000028C;
        21: a = 32'h00000146;  22: a = 32'h000000A3;  23: a = 32'h00000051;
        24: a = 32'h00000029;  25: a = 32'h00000014;  26: a = 32'h0000000A;
        27: a = 32'h00000005;  28: a = 32'h00000003;  29: a = 32'h00000001;
         default: a = 32'h00000000;
      endcase
      return $signed({1'b0, a});
   endfunction

endpackage

// ----- design/vem_isqrt.sv -----
// Pipelined integer square root, one result bit per stage.
module vem_isqrt import vem_pkg::*; #(
   parameter int RADIX_W = RAD_W,
   parameter int SIDE_W = 1
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  logic [RADIX_W-1:0]           radicand,
   input  logic [SIDE_W-1:0]            side_in,
   output logic                         out_valid,
   output logic [(RADIX_W+1)/2-1:0]     root,
   output logic [SIDE_W-1:0]            side_out
);

   localparam int STEPS = (RADIX_W + 1) / 2;
   localparam int W = 2 * STEPS + 1;

   logic [W-1:0]      rem_ff [1:STEPS];
   logic [W-1:0]      res_ff [1:STEPS];
   logic [SIDE_W-1:0] side_ff [1:STEPS];
   logic              vld_ff [1:STEPS];

   for (genvar k = 0; k < STEPS; k++) begin : g_step
      localparam logic [W-1:0] BIT = W'(1) << (2 * (STEPS - 1 - k));
      logic [W-1:0]      cur_rem;
      logic [W-1:0]      cur_res;
      logic [SIDE_W-1:0] cur_side;
      logic              cur_vld;
      logic [W-1:0]      trial;
      logic [W-1:0]      rem_in;
      logic [W-1:0]      res_in;

      if (k == 0) begin : g_first
         assign cur_rem = W'(radicand);
         assign cur_res = '0;
         assign cur_side = side_in;
         assign cur_vld = in_valid;
      end else begin : g_rest
         assign cur_rem = rem_ff[k];
         assign cur_res = res_ff[k];
         assign cur_side = side_ff[k];
         assign cur_vld = vld_ff[k];
      end

      // Try to subtract the next root bit from the remainder.
      always_comb begin
         trial = cur_res + BIT;
         if (cur_rem >= trial) begin
            rem_in = cur_rem - trial;
            res_in = (cur_res >> 1) + BIT;
         end else begin
            rem_in = cur_rem;
            res_in = cur_res >> 1;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[k+1] <= rem_in;
         res_ff[k+1] <= res_in;
         side_ff[k+1] <= cur_side;
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else begin
            vld_ff[k+1] <= cur_vld;
         end
      end
   end

   assign out_valid = vld_ff[STEPS];
   assign root = res_ff[STEPS][STEPS-1:0];
   assign side_out = side_ff[STEPS];

endmodule

// ----- design/vem_cordic.sv -----
// Pipelined CORDIC arctangent of num/den, one rotation step per stage.
module vem_cordic import vem_pkg::*; #(
   parameter int SIDE_W = 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic signed [CORD_NUM_W-1:0]  num,
   input  logic signed [CORD_NUM_W-1:0]  den,
   input  logic [SIDE_W-1:0]             side_in,
   output logic                          out_valid,
   output logic signed [ANG_W-1:0]       angle,
   output logic [SIDE_W-1:0]             side_out
);

   logic signed [CORD_XY_W-1:0] px_ff [0:CORDIC_STEPS];
   logic signed [CORD_XY_W-1:0] py_ff [0:CORDIC_STEPS];
   logic signed [ANG_W-1:0]     acc_ff [0:CORDIC_STEPS];
   logic                        zero_ff [0:CORDIC_STEPS];
   logic                        pos_ff [0:CORDIC_STEPS];
   logic [SIDE_W-1:0]           side_ff [0:CORDIC_STEPS];
   logic                        vld_ff [0:CORDIC_STEPS];

   logic signed [CORD_XY_W-1:0] px_in;
   logic signed [CORD_XY_W-1:0] py_in;

   // Entry stage: fold a negative divisor into the right half plane.
   always_comb begin
      if (den[CORD_NUM_W-1]) begin
         px_in = -CORD_XY_W'(den);
         py_in = -CORD_XY_W'(num);
      end else begin
         px_in = CORD_XY_W'(den);
         py_in = CORD_XY_W'(num);
      end
   end

   always_ff @(posedge clock) begin
      px_ff[0] <= px_in;
      py_ff[0] <= py_in;
      acc_ff[0] <= '0;
      zero_ff[0] <= (den == '0);
      pos_ff[0] <= !num[CORD_NUM_W-1];
      side_ff[0] <= side_in;
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else begin
         vld_ff[0] <= in_valid;
      end
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
      localparam logic signed [ANG_W-1:0] ARC = cordic_arc(i);
      logic signed [CORD_XY_W-1:0] dx;
      logic signed [CORD_XY_W-1:0] dy;
      logic signed [CORD_XY_W-1:0] px_n_in;
      logic signed [CORD_XY_W-1:0] py_n_in;
      logic signed [ANG_W-1:0]     acc_in;

      // Rotate toward the x axis by the step's angle.
      always_comb begin
         dx = py_ff[i] >>> i;
         dy = px_ff[i] >>> i;
         if (!py_ff[i][CORD_XY_W-1]) begin
            px_n_in = px_ff[i] + dx;
            py_n_in = py_ff[i] - dy;
            acc_in = acc_ff[i] + ARC;
         end else begin
            px_n_in = px_ff[i] - dx;
            py_n_in = py_ff[i] + dy;
            acc_in = acc_ff[i] - ARC;
         end
      end

      always_ff @(posedge clock) begin
         px_ff[i+1] <= px_n_in;
         py_ff[i+1] <= py_n_in;
         acc_ff[i+1] <= acc_in;
         zero_ff[i+1] <= zero_ff[i];
         pos_ff[i+1] <= pos_ff[i];
         side_ff[i+1] <= side_ff[i];
         if (reset) begin
            vld_ff[i+1] <= 1'b0;
         end else begin
            vld_ff[i+1] <= vld_ff[i];
         end
      end
   end

   // A zero divisor gives plus or minus a quarter turn.
   always_comb begin
      if (zero_ff[CORDIC_STEPS]) begin
         angle = pos_ff[CORDIC_STEPS] ? ANG_QUARTER : -ANG_QUARTER;
      end else begin
         angle = acc_ff[CORDIC_STEPS];
      end
   end

   assign out_valid = vld_ff[CORDIC_STEPS];
   assign side_out = side_ff[CORDIC_STEPS];

endmodule

// ----- design/viewport_to_equirect_map.sv -----
// Top level: maps a viewport pixel to its equirectangular sampling position.
// From the accepting edge to the result strobe a transaction passes nine front stages,
// 31 square root stages (one root bit each), 31 CORDIC stages and four output stages.
// Throughput is one transaction per cycle while busy is low; the strobe cannot be held
// off. Synchronous reset restores the registers and drops every valid bit; busy is a
// registered copy of reset, so it stays high during reset and falls in the cycle after it.
module viewport_to_equirect_map import vem_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_data,
   output logic                  rsp_valid,
   output rsp_type               rsp_data,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // Configuration registers.
   logic [FOCAL_W-1:0]        focal_ff;
   logic signed [QUAT_W-1:0]  qw_ff, qx_ff, qy_ff, qz_ff;
   logic [PLANE_W-1:0]        pw_ff, ph_ff;
   logic [EQH_W-1:0]          eh_ff;
   logic                      busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         focal_ff <= FOCAL_RST;
         qw_ff <= QUAT_W_RST;
         qx_ff <= QUAT_V_RST;
         qy_ff <= QUAT_V_RST;
         qz_ff <= QUAT_V_RST;
         pw_ff <= PLANE_W_RST;
         ph_ff <= PLANE_H_RST;
         eh_ff <= EQUI_H_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_FOCAL:   focal_ff <= csr_wdata[FOCAL_W-1:0];
            CSR_QUAT_W:  qw_ff <= $signed(csr_wdata[QUAT_W-1:0]);
            CSR_QUAT_X:  qx_ff <= $signed(csr_wdata[QUAT_W-1:0]);
            CSR_QUAT_Y:  qy_ff <= $signed(csr_wdata[QUAT_W-1:0]);
            CSR_QUAT_Z:  qz_ff <= $signed(csr_wdata[QUAT_W-1:0]);
            CSR_PLANE_W: pw_ff <= csr_wdata[PLANE_W-1:0];
            CSR_PLANE_H: ph_ff <= csr_wdata[PLANE_W-1:0];
            CSR_EQUI_H:  eh_ff <= csr_wdata[EQH_W-1:0];
            default:     eh_ff <= eh_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      busy_ff <= reset;
   end
   assign busy = busy_ff;

   // Rotation matrix, two register stages behind the quaternion registers.
   logic signed [QPROD_W-1:0] ww_ff, aa_ff, bb_ff, cc_ff, ab_ff, wc_ff, ac_ff, wb_ff, bc_ff, wa_ff;
   logic signed [MAT_W-1:0]   r00_ff, r01_ff, r02_ff, r10_ff, r11_ff, r12_ff;
   logic signed [MAT_W-1:0]   r20_ff, r21_ff, r22_ff;

   always_ff @(posedge clock) begin
      ww_ff <= qw_ff * qw_ff;
      aa_ff <= qx_ff * qx_ff;
      bb_ff <= qy_ff * qy_ff;
      cc_ff <= qz_ff * qz_ff;
      ab_ff <= qx_ff * qy_ff;
      wc_ff <= qw_ff * qz_ff;
      ac_ff <= qx_ff * qz_ff;
      wb_ff <= qw_ff * qy_ff;
      bc_ff <= qy_ff * qz_ff;
      wa_ff <= qw_ff * qx_ff;
   end

   always_ff @(posedge clock) begin
      r00_ff <= MAT_W'(ww_ff) + MAT_W'(aa_ff) - MAT_W'(bb_ff) - MAT_W'(cc_ff);
      r11_ff <= MAT_W'(ww_ff) - MAT_W'(aa_ff) + MAT_W'(bb_ff) - MAT_W'(cc_ff);
      r22_ff <= MAT_W'(ww_ff) - MAT_W'(aa_ff) - MAT_W'(bb_ff) + MAT_W'(cc_ff);
      r01_ff <= (MAT_W'(ab_ff) - MAT_W'(wc_ff)) <<< 1;
      r10_ff <= (MAT_W'(ab_ff) + MAT_W'(wc_ff)) <<< 1;
      r02_ff <= (MAT_W'(ac_ff) + MAT_W'(wb_ff)) <<< 1;
      r20_ff <= (MAT_W'(ac_ff) - MAT_W'(wb_ff)) <<< 1;
      r12_ff <= (MAT_W'(bc_ff) - MAT_W'(wa_ff)) <<< 1;
      r21_ff <= (MAT_W'(bc_ff) + MAT_W'(wa_ff)) <<< 1;
   end

   // Front valid chain.
   logic [FRONT_STAGES-1:0] fvld_ff;
   logic [FRONT_STAGES-1:0] fvld_in;

   assign fvld_in = {fvld_ff[FRONT_STAGES-2:0], start && !busy};

   always_ff @(posedge clock) begin
      if (reset) begin
         fvld_ff <= '0;
      end else begin
         fvld_ff <= fvld_in;
      end
   end

   // Stage 1: capture the transaction.
   req_type req_ff;

   always_ff @(posedge clock) begin
      req_ff <= req_data;
   end

   // Stage 2: center the pixel on the image plane.
   logic signed [VEC_W-1:0] vx_ff, vy_ff, vz_ff;

   always_ff @(posedge clock) begin
      vx_ff <= $signed({2'b00, req_ff.pixel_col, 8'b0}) - $signed({2'b00, pw_ff, 7'b0});
      vy_ff <= $signed({2'b00, req_ff.pixel_row, 8'b0}) - $signed({2'b00, ph_ff, 7'b0});
      vz_ff <= $signed({2'b00, focal_ff});
   end

   // Stage 3: matrix times vector products.
   logic signed [PROD_W-1:0] pxx_ff, pxy_ff, pxz_ff, pyx_ff, pyy_ff, pyz_ff;
   logic signed [PROD_W-1:0] pzx_ff, pzy_ff, pzz_ff;

   always_ff @(posedge clock) begin
      pxx_ff <= r00_ff * vx_ff;
      pxy_ff <= r01_ff * vy_ff;
      pxz_ff <= r02_ff * vz_ff;
      pyx_ff <= r10_ff * vx_ff;
      pyy_ff <= r11_ff * vy_ff;
      pyz_ff <= r12_ff * vz_ff;
      pzx_ff <= r20_ff * vx_ff;
      pzy_ff <= r21_ff * vy_ff;
      pzz_ff <= r22_ff * vz_ff;
   end

   // Stage 4: rotated ray.
   logic signed [RAY_W-1:0] rx_ff, ry_ff, rz_ff;

   always_ff @(posedge clock) begin
      rx_ff <= RAY_W'(pxx_ff) + RAY_W'(pxy_ff) + RAY_W'(pxz_ff);
      ry_ff <= RAY_W'(pyx_ff) + RAY_W'(pyy_ff) + RAY_W'(pyz_ff);
      rz_ff <= RAY_W'(pzx_ff) + RAY_W'(pzy_ff) + RAY_W'(pzz_ff);
   end

   // Stage 5: sign and magnitude of each component.
   logic [MAG_W-1:0] mx_ff, my_ff, mz_ff;
   logic             sx_ff, sy_ff, sz_ff;

   always_ff @(posedge clock) begin
      mx_ff <= rx_ff[RAY_W-1] ? MAG_W'(-rx_ff) : MAG_W'(rx_ff);
      my_ff <= ry_ff[RAY_W-1] ? MAG_W'(-ry_ff) : MAG_W'(ry_ff);
      mz_ff <= rz_ff[RAY_W-1] ? MAG_W'(-rz_ff) : MAG_W'(rz_ff);
      sx_ff <= rx_ff[RAY_W-1];
      sy_ff <= ry_ff[RAY_W-1];
      sz_ff <= rz_ff[RAY_W-1];
   end

   // Stage 6: bit length of the largest magnitude.
   logic [MAG_W-1:0] m6x_ff, m6y_ff, m6z_ff, mor;
   logic             s6x_ff, s6y_ff, s6z_ff;
   logic [LEN_W-1:0] len_in, len_ff;

   always_comb begin
      mor = mx_ff | my_ff | mz_ff;
      len_in = '0;
      for (int i = 0; i < MAG_W; i++) begin
         if (mor[i]) begin
            len_in = LEN_W'(i + 1);
         end
      end
   end

   always_ff @(posedge clock) begin
      m6x_ff <= mx_ff;
      m6y_ff <= my_ff;
      m6z_ff <= mz_ff;
      s6x_ff <= sx_ff;
      s6y_ff <= sy_ff;
      s6z_ff <= sz_ff;
      len_ff <= len_in;
   end

   // Stage 7: normalize so the largest magnitude lies in [2^29, 2^30).
   logic [LEN_W-1:0]         sh_r, sh_l;
   logic                     go_right;
   logic [NORM_W-1:0]        nmx, nmy, nmz;
   logic [NORM_W-1:0]        nmx_ff, nmz_ff;
   logic signed [NVEC_W-1:0] nx_ff, ny_ff, nz_ff;

   always_comb begin
      go_right = len_ff > LEN_W'(NORM_W);
      sh_r = len_ff - LEN_W'(NORM_W);
      sh_l = LEN_W'(NORM_W) - len_ff;
      if (go_right) begin
         nmx = NORM_W'(m6x_ff >> sh_r);
         nmy = NORM_W'(m6y_ff >> sh_r);
         nmz = NORM_W'(m6z_ff >> sh_r);
      end else begin
         nmx = NORM_W'(m6x_ff << sh_l);
         nmy = NORM_W'(m6y_ff << sh_l);
         nmz = NORM_W'(m6z_ff << sh_l);
      end
   end

   always_ff @(posedge clock) begin
      nmx_ff <= nmx;
      nmz_ff <= nmz;
      nx_ff <= s6x_ff ? -$signed({1'b0, nmx}) : $signed({1'b0, nmx});
      ny_ff <= s6y_ff ? -$signed({1'b0, nmy}) : $signed({1'b0, nmy});
      nz_ff <= s6z_ff ? -$signed({1'b0, nmz}) : $signed({1'b0, nmz});
   end

   // Stage 8: squares of the horizontal components.
   logic [SQ_W-1:0]          sqx_ff, sqz_ff;
   logic signed [NVEC_W-1:0] n8x_ff, n8y_ff, n8z_ff;

   always_ff @(posedge clock) begin
      sqx_ff <= nmx_ff * nmx_ff;
      sqz_ff <= nmz_ff * nmz_ff;
      n8x_ff <= nx_ff;
      n8y_ff <= ny_ff;
      n8z_ff <= nz_ff;
   end

   // Stage 9: radicand for the horizontal length.
   logic [RAD_W-1:0]         rad_ff;
   logic [3*NVEC_W-1:0]      nvec_ff;

   always_ff @(posedge clock) begin
      rad_ff <= RAD_W'(sqx_ff) + RAD_W'(sqz_ff);
      nvec_ff <= {n8x_ff, n8y_ff, n8z_ff};
   end

   // Square root pipeline.
   logic                 sq_vld;
   logic [ROOT_W-1:0]    root;
   logic [3*NVEC_W-1:0]  sq_side;
   logic signed [NVEC_W-1:0] qx, qy, qz;

   vem_isqrt #(
      .RADIX_W (RAD_W),
      .SIDE_W  (3 * NVEC_W)
   ) u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fvld_ff[FRONT_STAGES-1]),
      .radicand  (rad_ff),
      .side_in   (nvec_ff),
      .out_valid (sq_vld),
      .root      (root),
      .side_out  (sq_side)
   );

   assign qx = $signed(sq_side[3*NVEC_W-1:2*NVEC_W]);
   assign qy = $signed(sq_side[2*NVEC_W-1:NVEC_W]);
   assign qz = $signed(sq_side[NVEC_W-1:0]);

   // Latitude and longitude arctangents run side by side.
   logic                    ang_vld;
   logic signed [ANG_W-1:0] lat_ang, lon_ang;
   logic                    zpos;

   vem_cordic #(
      .SIDE_W (1)
   ) u_cordic_lat (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sq_vld),
      .num       (CORD_NUM_W'(qy)),
      .den       ($signed({1'b0, root})),
      .side_in   (1'b0),
      .out_valid (ang_vld),
      .angle     (lat_ang),
      .side_out  ()
   );

   vem_cordic #(
      .SIDE_W (1)
   ) u_cordic_lon (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sq_vld),
      .num       (CORD_NUM_W'(qx)),
      .den       (CORD_NUM_W'(qz)),
      .side_in   (qz > 0),
      .out_valid (),
      .angle     (lon_ang),
      .side_out  (zpos)
   );

   // Back valid chain.
   logic [BACK_STAGES-1:0] bvld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bvld_ff <= '0;
      end else begin
         bvld_ff <= {bvld_ff[BACK_STAGES-2:0], ang_vld};
      end
   end

   // Back stage 1: turn the longitude by half a turn, wrapped into range, when the ray's z is not positive.
   logic signed [LON_W-1:0] lon_t, lon_in, lon_ff, lat_ff;

   always_comb begin
      lon_t = LON_W'(lon_ang) - ANG_HALF;
      if (zpos) begin
         lon_in = LON_W'(lon_ang);
      end else if (lon_t < -ANG_HALF) begin
         lon_in = lon_t + ANG_FULL;
      end else begin
         lon_in = lon_t;
      end
   end

   always_ff @(posedge clock) begin
      lon_ff <= lon_in;
      lat_ff <= LON_W'(lat_ang);
   end

   // Back stage 2: scale by the image height.
   logic signed [SCL_W-1:0] xp_ff, yp_ff;
   logic signed [EQH_W:0]   eh_s;

   assign eh_s = $signed({1'b0, eh_ff});

   always_ff @(posedge clock) begin
      xp_ff <= lon_ff * eh_s;
      yp_ff <= lat_ff * eh_s;
   end

   // Back stage 3: round half up and add the image center.
   localparam int RND_SHIFT = 31 - FRAC_BITS;
   localparam logic signed [OUT_W-1:0] RND_HALF = OUT_W'(64'sd1 <<< (30 - FRAC_BITS));

   logic signed [OUT_W-1:0] ox_ff, oy_ff, cx, cy;

   assign cx = $signed(OUT_W'({eh_ff, {FRAC_BITS{1'b0}}}));
   assign cy = $signed(OUT_W'({eh_ff, {(FRAC_BITS-1){1'b0}}}));

   always_ff @(posedge clock) begin
      ox_ff <= ((OUT_W'(xp_ff) + RND_HALF) >>> RND_SHIFT) + cx;
      oy_ff <= ((OUT_W'(yp_ff) + RND_HALF) >>> RND_SHIFT) + cy;
   end

   // Back stage 4: clamp into the image.
   logic signed [OUT_W-1:0] hx, hy;
   logic [EQX_W-1:0]        ex_in;
   logic [EQY_W-1:0]        ey_in;

   assign hx = $signed(OUT_W'({eh_ff, {(FRAC_BITS+1){1'b0}}}));
   assign hy = cx;

   always_comb begin
      if (ox_ff[OUT_W-1]) begin
         ex_in = '0;
      end else if (ox_ff > hx) begin
         ex_in = EQX_W'(hx);
      end else begin
         ex_in = EQX_W'(ox_ff);
      end
      if (oy_ff[OUT_W-1]) begin
         ey_in = '0;
      end else if (oy_ff > hy) begin
         ey_in = EQY_W'(hy);
      end else begin
         ey_in = EQY_W'(oy_ff);
      end
   end

   rsp_type rsp_ff;

   always_ff @(posedge clock) begin
      rsp_ff.equi_x <= ex_in;
      rsp_ff.equi_y <= ey_in;
   end

   assign rsp_data = rsp_ff;
   assign rsp_valid = bvld_ff[BACK_STAGES-1];

endmodule

// ----- design/vem_checker.sv -----
// Port-level checker for the viewport map block and its bind statement.
`include "viewport_to_equirect_map_macros.svh"

module vem_checker import vem_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_valid,
   input rsp_type rsp_data
);

   // Every accepted transaction gives exactly one result after the fixed latency.
   `VEM_ASSERT_IMPL(a_rsp_after_accept, start && !busy, ##RSP_LATENCY rsp_valid)
   `VEM_ASSERT_IMPL(a_rsp_has_source, rsp_valid, $past(start && !busy, RSP_LATENCY))

   // Busy only follows reset.
   `VEM_ASSERT_IMPL(a_busy_after_reset, busy, $past(reset))

   // The column never exceeds the widest possible image.
   `VEM_ASSERT_IMPL(a_col_bound, rsp_valid, rsp_data.equi_x <= EQX_BOUND)

endmodule

bind viewport_to_equirect_map vem_checker u_vem_checker (.*);
